// ----- design/kuf_pkg.sv -----
// Shared types and constants for the Kruskal union-find edge block.
package kuf_pkg;

  localparam int KUF_MAX_VERTICES = 1024;
  localparam int KUF_FIELD_W      = 11;
  localparam int KUF_DATA_W       = 24;

  localparam logic KUF_CMD_CLEAR = 1'b0;
  localparam logic KUF_CMD_EDGE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_CLEAR_CMD,
    ST_IDLE,
    ST_START,
    ST_F_RD,
    ST_F_WALK,
    ST_C_CHK,
    ST_C_WR,
    ST_UNION,
    ST_DIV,
    ST_RESULT
  } kuf_state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ERR,
    RES_ACC
  } kuf_res_t;

  typedef struct packed {
    logic     load_item;
    logic     clr_start;
    logic     clr_step;
    logic     find_init;
    logic     sel_b;
    logic     rd_cur;
    logic     walk_up;
    logic     set_root;
    logic     compress;
    logic     save_ra;
    logic     do_union;
    logic     div_step;
    logic     set_kind;
    kuf_res_t kind;
    logic     out_load;
  } kuf_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic bad_ep;
    logic root_hit;
    logic at_root;
    logic same_root;
    logic clr_last;
    logic div_last;
  } kuf_sts_t;

endpackage

// ----- design/kuf_ctrl.sv -----
// Controller state machine for the union-find edge block.
module kuf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  kuf_pkg::kuf_sts_t sts,
  output kuf_pkg::kuf_cmd_t cmd
);
  import kuf_pkg::*;

  kuf_state_t state_r, state_nxt;
  logic       side_r, side_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.kind  = RES_ZERO;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_CLEAR_CMD: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = RES_ZERO;
          state_nxt    = ST_RESULT;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_START;
        end
      end
      ST_START: begin
        if (sts.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLEAR_CMD;
        end else if (sts.bad_ep) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = RES_ERR;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.find_init = 1'b1;
          side_nxt      = 1'b0;
          state_nxt     = ST_F_RD;
        end
      end
      ST_F_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = ST_F_WALK;
      end
      ST_F_WALK: begin
        if (sts.root_hit) begin
          cmd.set_root = 1'b1;
          state_nxt    = ST_C_CHK;
        end else begin
          cmd.walk_up = 1'b1;
        end
      end
      ST_C_CHK: begin
        if (sts.at_root) begin
          if (!side_r) begin
            cmd.save_ra   = 1'b1;
            cmd.find_init = 1'b1;
            cmd.sel_b     = 1'b1;
            side_nxt      = 1'b1;
            state_nxt     = ST_F_RD;
          end else begin
            state_nxt = ST_UNION;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = ST_C_WR;
        end
      end
      ST_C_WR: begin
        cmd.compress = 1'b1;
        state_nxt    = ST_C_CHK;
      end
      ST_UNION: begin
        cmd.set_kind = 1'b1;
        if (sts.same_root) begin
          cmd.kind  = RES_ZERO;
          state_nxt = ST_RESULT;
        end else begin
          cmd.kind     = RES_ACC;
          cmd.do_union = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  // a new result never overwrites one that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> slot_free)
    else $error("result loaded over a pending beat");

  // a stalled result stays up
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("result dropped while stalled");

  // nothing is accepted during a clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_CLEAR_CMD) |-> !in_tready)
    else $error("input accepted during clear");

endmodule

// ----- design/kuf_dp.sv -----
// Datapath: parent memory, find walk registers, dividers and result registers.
module kuf_dp #(
  parameter int MAX_VERTICES = kuf_pkg::KUF_MAX_VERTICES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kuf_pkg::KUF_FIELD_W-1:0]  cfg_width,
  input  logic                             in_command,
  input  logic [kuf_pkg::KUF_FIELD_W-1:0]  in_ep_a,
  input  logic [kuf_pkg::KUF_FIELD_W-1:0]  in_ep_b,
  input  kuf_pkg::kuf_cmd_t                cmd,
  output kuf_pkg::kuf_sts_t                sts,
  output logic                             res_accepted,
  output logic [kuf_pkg::KUF_FIELD_W-1:0]  res_row,
  output logic [kuf_pkg::KUF_FIELD_W-1:0]  res_col,
  output logic                             res_error
);
  import kuf_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int FW = KUF_FIELD_W;

  logic [VW-1:0] mem [MAX_VERTICES];

  logic [FW-1:0] width_r;
  logic          command_r;
  logic [FW-1:0] ep_a_r, ep_b_r;
  logic [VW-1:0] cur_r, start_r, root_r, ra_r, rd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic [3:0]    div_cnt_r;
  logic [FW:0]   rem_r [2];
  logic [FW-1:0] quo_r [2];
  kuf_res_t      kind_r;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [VW-1:0] wd;
  logic [VW-1:0] cur_m1, rdd_m1, hi, lo, hi_m1, vert_a, vert_b;
  logic [FW-1:0] w_eff;
  logic [FW:0]   row_sum, col_sum;

  // one restoring division step: {rem, quo}
  function automatic logic [2*FW:0] div_one(input logic [FW:0] rem,
                                            input logic [FW-1:0] quo,
                                            input logic [FW-1:0] dv);
    logic [FW:0] t;
    t = {rem[FW-1:0], quo[FW-1]};
    if (t >= {1'b0, dv}) div_one = {t - {1'b0, dv}, quo[FW-2:0], 1'b1};
    else                 div_one = {t, quo[FW-2:0], 1'b0};
  endfunction

  assign w_eff  = (width_r == '0) ? FW'(1) : width_r;
  assign vert_a = VW'(ep_a_r);
  assign vert_b = VW'(ep_b_r);
  assign cur_m1 = cur_r - VW'(1);
  assign rdd_m1 = rd_data_r - VW'(1);
  assign hi     = (ra_r > root_r) ? ra_r : root_r;
  assign lo     = (ra_r > root_r) ? root_r : ra_r;
  assign hi_m1  = hi - VW'(1);

  always_comb begin
    we = 1'b0;
    wa = clr_cnt_r;
    wd = VW'(clr_cnt_r) + VW'(1);
    if (cmd.compress) begin
      we = 1'b1;
      wa = cur_m1[AW-1:0];
      wd = root_r;
    end else if (cmd.do_union) begin
      we = 1'b1;
      wa = hi_m1[AW-1:0];
      wd = lo;
    end else if (cmd.clr_step) begin
      we = 1'b1;
    end
    re = cmd.rd_cur || cmd.walk_up;
    ra = cmd.walk_up ? rdd_m1[AW-1:0] : cur_m1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= FW'(1);
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) width_r <= cfg_width;
      if (cmd.clr_start)     clr_cnt_r <= '0;
      else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      command_r <= in_command;
      ep_a_r    <= in_ep_a;
      ep_b_r    <= in_ep_b;
    end
    if (cmd.find_init) begin
      cur_r   <= cmd.sel_b ? vert_b : vert_a;
      start_r <= cmd.sel_b ? vert_b : vert_a;
    end else if (cmd.walk_up) begin
      cur_r <= rd_data_r;
    end else if (cmd.set_root) begin
      root_r <= cur_r;
      cur_r  <= start_r;
    end else if (cmd.compress) begin
      cur_r <= rd_data_r;
    end
    if (cmd.save_ra) ra_r <= root_r;
    if (cmd.set_kind) kind_r <= cmd.kind;
    if (cmd.do_union) begin
      div_cnt_r <= '0;
      rem_r[0]  <= '0;
      rem_r[1]  <= '0;
      quo_r[0]  <= ep_a_r - FW'(1);
      quo_r[1]  <= ep_b_r - FW'(1);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 4'd1;
      for (int i = 0; i < 2; i++) begin
        {rem_r[i], quo_r[i]} <= div_one(rem_r[i], quo_r[i], w_eff);
      end
    end
  end

  assign row_sum = {1'b0, quo_r[0]} + {1'b0, quo_r[1]} + (FW+1)'(1);
  assign col_sum = {1'b0, rem_r[0][FW-1:0]} + {1'b0, rem_r[1][FW-1:0]} + (FW+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_accepted <= 1'b0;
      res_error    <= 1'b0;
      res_row      <= '0;
      res_col      <= '0;
      case (kind_r)
        RES_ERR: res_error <= 1'b1;
        RES_ACC: begin
          res_accepted <= 1'b1;
          res_row      <= row_sum[FW-1:0];
          res_col      <= col_sum[FW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.is_clear  = (command_r == KUF_CMD_CLEAR);
    sts.bad_ep    = (ep_a_r == '0) || (ep_b_r == '0)
                 || ({21'd0, ep_a_r} > 32'(MAX_VERTICES))
                 || ({21'd0, ep_b_r} > 32'(MAX_VERTICES));
    sts.root_hit  = (rd_data_r == cur_r);
    sts.at_root   = (cur_r == root_r);
    sts.same_root = (ra_r == root_r);
    sts.clr_last  = (clr_cnt_r == AW'(MAX_VERTICES - 1));
    sts.div_last  = (div_cnt_r == 4'(FW - 1));
  end

endmodule

// ----- design/kruskal_edge_union_find.sv -----
// Top level of the Kruskal union-find edge block.
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | tdata: endpoint_a, endpoint_b; tuser: command
//  out_    | output    | out_tvalid/out_tready | tdata: wall_row, wall_col; tuser: accepted, error
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_data: grid_width
// After reset the parent memory is swept, one entry per cycle, with in_tready low. A clear
// beat runs the same sweep before its result. An edge beat runs a find for both endpoints on the
// parent memory, then, when accepted, the two bit-serial wall dividers. A bad endpoint goes
// from the start state straight to its error result. One beat is worked on at a time; a finished
// result waits in the output register while the next beat is taken.
module kruskal_edge_union_find #(
  parameter int MAX_VERTICES = kuf_pkg::KUF_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kuf_pkg::KUF_DATA_W-1:0]      in_tdata,   // endpoint_a[10:0], endpoint_b[21:11]
  input  logic                                in_tuser,   // command[0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kuf_pkg::KUF_DATA_W-1:0]      out_tdata,  // wall_row[10:0], wall_col[21:11]
  output logic [1:0]                          out_tuser,  // accepted[0], error[1]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kuf_pkg::KUF_FIELD_W-1:0]     cfg_data    // grid_width
);
  import kuf_pkg::*;

  kuf_cmd_t          cmd;
  kuf_sts_t          sts;
  logic              res_accepted, res_error;
  logic [KUF_FIELD_W-1:0] res_row, res_col;

  assign cfg_ready = 1'b1;

  kuf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kuf_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_width    (cfg_data),
    .in_command   (in_tuser),
    .in_ep_a      (in_tdata[KUF_FIELD_W-1:0]),
    .in_ep_b      (in_tdata[2*KUF_FIELD_W-1:KUF_FIELD_W]),
    .cmd          (cmd),
    .sts          (sts),
    .res_accepted (res_accepted),
    .res_row      (res_row),
    .res_col      (res_col),
    .res_error    (res_error)
  );

  assign out_tdata = {(KUF_DATA_W - 2*KUF_FIELD_W)'(0), res_col, res_row};
  assign out_tuser = {res_error, res_accepted};

endmodule
